### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nfs assertion failed");

// Next-cycle implication.
`define NFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nfs assertion failed");

`endif

### rtl/nfs_pkg.sv
// ----------------------------------------------------------------------------
// nfs_pkg
// Types and constants shared by the nearest fingerprint search block.
// ----------------------------------------------------------------------------
package nfs_pkg;

  localparam int unsigned READ_W    = 16;  // Q8.8 reading
  localparam int unsigned SQ_W      = 32;  // one squared difference, < 2^32
  localparam int unsigned DIST_W    = 34;  // sum over up to four sensors
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned POS_W     = 8;   // scan position, grids up to 256
  localparam int unsigned OUT_POS_W = 4;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CFG_W-1:0] ROWS_RST = 5'd16;
  localparam logic [CFG_W-1:0] COLS_RST = 5'd16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Register select, taken from paddr[2]
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } scan_tag_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DIST_W-1:0] dist_sq;
  } best_t;

endpackage

### rtl/nearest_fingerprint_search_top.sv
// ----------------------------------------------------------------------------
// nearest_fingerprint_search_top
// Calibration grid of sensor fingerprints with a nearest-cell search by
// squared Euclidean distance, one sensor lane per reading.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  in      | in        | in_valid_i/in_stall_o | opcode, row, column, reading_0..3
//  out     | out       | out_valid_o/out_stall_i| best_row, best_col, best_dist_sq, found
//  cfg     | in        | APB, pready tied high | rows_in_use @0x0, cols_in_use @0x4
//
//  A write word gives no result.
//  A query word scans the nr*nc cells in use (nr, nc being the saturated
//  rows and columns in use), reading one cell a cycle from the lane RAMs;
//  then the RAM read, square and merge stages drain. An empty grid skips the scan.
//  After reset a clearing pass zeroes the store, during which in_stall_o is
//  high; APB writes are taken throughout.
//  The result sits in an output register, so a stalled result does not stop
//  the next word being taken; a finished query waits only if that register
//  is still full.
// ----------------------------------------------------------------------------
module nearest_fingerprint_search_top #(
  parameter int unsigned SENSORS  = 4,
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 opcode_i,
  input  logic [3:0]                           row_i,
  input  logic [3:0]                           column_i,
  input  logic signed [15:0]                   reading_0_i,
  input  logic signed [15:0]                   reading_1_i,
  input  logic signed [15:0]                   reading_2_i,
  input  logic signed [15:0]                   reading_3_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [3:0]                           best_row_o,
  output logic [3:0]                           best_col_o,
  output logic [33:0]                          best_dist_sq_o,
  output logic                                 found_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nfs_pkg::APB_AW-1:0]           paddr,
  input  logic [nfs_pkg::APB_DW-1:0]           pwdata,
  output logic [nfs_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned MW    = (RW > CW) ? RW : CW;
  localparam int unsigned LIM_W = ((MW > nfs_pkg::CFG_W) ? MW : nfs_pkg::CFG_W) + 1;
  localparam int unsigned RDW   = nfs_pkg::READ_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [nfs_pkg::CFG_W-1:0] rows_q, rows_d;
  logic [nfs_pkg::CFG_W-1:0] cols_q, cols_d;
  logic                      cfg_wr;
  nfs_pkg::reg_idx_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = nfs_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_wr) begin
      case (cfg_sel)
        nfs_pkg::REG_ROWS: rows_d = pwdata[nfs_pkg::CFG_W-1:0];
        nfs_pkg::REG_COLS: cols_d = pwdata[nfs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      nfs_pkg::REG_ROWS: prdata = nfs_pkg::APB_DW'(rows_q);
      nfs_pkg::REG_COLS: prdata = nfs_pkg::APB_DW'(cols_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= nfs_pkg::ROWS_RST;
      cols_q <= nfs_pkg::COLS_RST;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  // Grid extent in use, saturated to the store size
  logic [LIM_W-1:0] nr, nc;
  logic             grid_empty;

  assign nr = (LIM_W'(rows_q) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : LIM_W'(rows_q);
  assign nc = (LIM_W'(cols_q) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS) : LIM_W'(cols_q);
  assign grid_empty = (nr == '0) || (nc == '0);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  nfs_pkg::state_e state_q, state_d;

  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] clr_q, clr_d;

  logic in_acc, query_start, wr_we, wr_in_grid;
  logic row_last, col_last, clr_last;
  logic issue, clear_we, load_out;
  logic merge_done;
  logic [AW-1:0] wr_addr;

  nfs_pkg::best_t     best;
  nfs_pkg::scan_tag_t tag_s0, tag_p1_q, tag_p2_q;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign query_start = in_acc && (opcode_i == nfs_pkg::OP_QUERY);
  assign wr_in_grid  = (32'(row_i) < MAX_ROWS) && (32'(column_i) < MAX_COLS);
  assign wr_we       = in_acc && (opcode_i == nfs_pkg::OP_WRITE) && wr_in_grid;
  assign wr_addr     = AW'(32'(row_i) * MAX_COLS + 32'(column_i));

  assign row_last = (LIM_W'(r_q) == (nr - LIM_W'(1)));
  assign col_last = (LIM_W'(c_q) == (nc - LIM_W'(1)));
  assign clr_last = (clr_q == AW'(CELLS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nfs_pkg::ST_CLEAR: begin
        if (clr_last) state_d = nfs_pkg::ST_IDLE;
      end
      nfs_pkg::ST_IDLE: begin
        if (query_start) state_d = grid_empty ? nfs_pkg::ST_HOLD : nfs_pkg::ST_SCAN;
      end
      nfs_pkg::ST_SCAN: begin
        if (row_last && col_last) state_d = nfs_pkg::ST_FLUSH;
      end
      nfs_pkg::ST_FLUSH: begin
        if (merge_done) state_d = nfs_pkg::ST_HOLD;
      end
      nfs_pkg::ST_HOLD: begin
        if (!out_valid_o || !out_stall_i) state_d = nfs_pkg::ST_IDLE;
      end
      default: state_d = nfs_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    clear_we   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      nfs_pkg::ST_CLEAR: clear_we   = 1'b1;
      nfs_pkg::ST_IDLE:  in_stall_o = 1'b0;
      nfs_pkg::ST_SCAN:  issue      = 1'b1;
      nfs_pkg::ST_FLUSH: ;
      nfs_pkg::ST_HOLD:  load_out   = !out_valid_o || !out_stall_i;
      default: ;
    endcase
  end

  // Row-major scan: address is row base plus column
  always_comb begin
    r_d    = r_q;
    c_d    = c_q;
    addr_d = addr_q;
    base_d = base_q;
    clr_d  = clr_q;
    if (clear_we) begin
      clr_d = clr_q + AW'(1);
    end
    if (query_start) begin
      r_d    = '0;
      c_d    = '0;
      addr_d = '0;
      base_d = '0;
    end else if (issue) begin
      if (col_last) begin
        r_d    = r_q + RW'(1);
        c_d    = '0;
        base_d = base_q + AW'(MAX_COLS);
        addr_d = base_q + AW'(MAX_COLS);
      end else begin
        c_d    = c_q + CW'(1);
        addr_d = addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfs_pkg::ST_CLEAR;
      r_q     <= '0;
      c_q     <= '0;
      addr_q  <= '0;
      base_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      addr_q  <= addr_d;
      base_q  <= base_d;
      clr_q   <= clr_d;
    end
  end

  // Cell tag follows the RAM read and the square stage
  always_comb begin
    tag_s0.valid = issue;
    tag_s0.last  = row_last && col_last;
    tag_s0.row   = nfs_pkg::POS_W'(r_q);
    tag_s0.col   = nfs_pkg::POS_W'(c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_p1_q <= '0;
      tag_p2_q <= '0;
    end else begin
      tag_p1_q <= tag_s0;
      tag_p2_q <= tag_p1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Sensor lanes
  // --------------------------------------------------------------------------
  logic [RDW-1:0]            reading_w [4];
  logic [nfs_pkg::SQ_W-1:0]  sq_w [SENSORS];
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;

  assign reading_w[0] = reading_0_i;
  assign reading_w[1] = reading_1_i;
  assign reading_w[2] = reading_2_i;
  assign reading_w[3] = reading_3_i;

  assign ram_we    = clear_we || wr_we;
  assign ram_waddr = clear_we ? clr_q : wr_addr;

  for (genvar s = 0; s < SENSORS; s++) begin : g_lane
    nfs_lane #(
      .DEPTH(CELLS)
    ) u_lane (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(ram_waddr),
      .wdata_i(clear_we ? '0 : reading_w[s]),
      .raddr_i(addr_q),
      .load_i (query_start),
      .meas_i (reading_w[s]),
      .sq_o   (sq_w[s])
    );
  end

  nfs_merge #(
    .SENSORS(SENSORS)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(query_start),
    .tag_i  (tag_p2_q),
    .sq_i   (sq_w),
    .best_o (best),
    .done_o (merge_done)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                       out_valid_q, out_valid_d;
  logic [3:0]                 out_row_q, out_col_q;
  logic [nfs_pkg::DIST_W-1:0] out_dist_q;
  logic                       out_found_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q   <= best.row[nfs_pkg::OUT_POS_W-1:0];
      out_col_q   <= best.col[nfs_pkg::OUT_POS_W-1:0];
      out_dist_q  <= best.dist_sq;
      out_found_q <= best.found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_row_o     = out_row_q;
  assign best_col_o     = out_col_q;
  assign best_dist_sq_o = out_dist_q;
  assign found_o        = out_found_q;

endmodule

### rtl/nfs_ram.sv
// ----------------------------------------------------------------------------
// nfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nfs_lane.sv
// ----------------------------------------------------------------------------
// nfs_lane
// One sensor lane: holds that sensor's calibration readings and squares the
// difference to the measurement for the cell being scanned.
// ----------------------------------------------------------------------------
module nfs_lane #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [nfs_pkg::READ_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic                      load_i,
  input  logic [nfs_pkg::READ_W-1:0] meas_i,
  output logic [nfs_pkg::SQ_W-1:0]  sq_o
);

  localparam int unsigned RW = nfs_pkg::READ_W;

  logic [RW-1:0]            stored;
  logic [RW-1:0]            meas_q;
  logic signed [RW:0]       diff;
  logic signed [2*RW+1:0]   prod;
  logic [nfs_pkg::SQ_W-1:0] sq_q;

  nfs_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(stored)
  );

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      meas_q <= meas_i;
    end
  end

  // Difference lies within +-65535, so the square fits in 32 bits
  assign diff = $signed({meas_q[RW-1], meas_q}) - $signed({stored[RW-1], stored});
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    sq_q <= prod[nfs_pkg::SQ_W-1:0];
  end

  assign sq_o = sq_q;

endmodule

### rtl/nfs_merge.sv
// ----------------------------------------------------------------------------
// nfs_merge
// Sums the lane squares of one cell, then keeps the first cell with the
// least distance seen since the query started.
// ----------------------------------------------------------------------------
module nfs_merge #(
  parameter int unsigned SENSORS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  nfs_pkg::scan_tag_t       tag_i,
  input  logic [nfs_pkg::SQ_W-1:0] sq_i [SENSORS],
  output nfs_pkg::best_t           best_o,
  output logic                     done_o
);

  logic [nfs_pkg::DIST_W-1:0] sum_d, sum_q;
  nfs_pkg::scan_tag_t         tag_q;
  nfs_pkg::best_t             best_d, best_q;
  logic                       done_d, done_q;

  always_comb begin
    sum_d = '0;
    for (int s = 0; s < SENSORS; s++) begin
      sum_d = sum_d + nfs_pkg::DIST_W'(sq_i[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Strict less-than keeps the earlier cell on a tie
  always_comb begin
    best_d = best_q;
    done_d = 1'b0;
    if (start_i) begin
      best_d = '0;
    end else if (tag_q.valid) begin
      done_d = tag_q.last;
      if (!best_q.found || (sum_q < best_q.dist_sq)) begin
        best_d.found   = 1'b1;
        best_d.row     = tag_q.row;
        best_d.col     = tag_q.col;
        best_d.dist_sq = sum_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      best_q <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      best_q <= best_d;
      done_q <= done_d;
    end
  end

  assign best_o = best_q;
  assign done_o = done_q;

endmodule

### rtl/nfs_checker.sv
// ----------------------------------------------------------------------------
// nfs_checker
// Port-level checks on the nearest fingerprint search block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  best_row_o,
  input logic [3:0]  best_col_o,
  input logic [33:0] best_dist_sq_o,
  input logic        found_o
);

  logic [42:0] out_word;
  logic        query_acc;

  assign out_word  = {best_row_o, best_col_o, best_dist_sq_o, found_o};
  assign query_acc = in_valid_i && !in_stall_o && (opcode_i == nfs_pkg::OP_QUERY);

  // A stalled result holds
  `NFS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // Empty grid reports all zeros
  `NFS_ASSERT_IMP(a_empty_zero, out_valid_o && !found_o, out_word == '0)

  // A query keeps the block busy for at least the following cycle
  `NFS_ASSERT_NXT(a_query_busy, query_acc, in_stall_o)

  // A new result only appears at the end of a query's work
  `NFS_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind nearest_fingerprint_search_top nfs_checker u_nfs_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_fingerprint_search_top. A driver feeds
// calibration writes and queries from a queue, a shadow grid predicts the
// nearest cell of every query, and a monitor compares each result word with
// the oldest prediction. The grid size in use is reprogrammed over APB
// between phases, with read-back.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_ROWS  = 16;
  localparam int GRID_COLS  = 16;
  localparam int SENSOR_CNT = 4;

  // write words give no result; the settle wait covers one still in flight
  localparam int SETTLE_CYCLES = 16;
  // drain wait, sized from the full-grid scan
  localparam int DRAIN_CYCLES  = GRID_ROWS * GRID_COLS + 40;
  // receiver back-pressure stretch, long enough to fill the block
  localparam int HOLD_CYCLES   = 500;
  // slowest run: ~1800 words at full-grid latency plus idles, taken a few
  // times over
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  typedef enum int {
    IDLE_RX_HEAVY,  // sender 23 %, receiver 45 %
    IDLE_TX_HEAVY,  // sender 45 %, receiver 23 %
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    nfs_pkg::opcode_e op;
    logic [3:0]       row;
    logic [3:0]       col;
    logic [3:0][15:0] rd;
  } fp_word_t;

  typedef struct packed {
    logic [3:0]                 row;
    logic [3:0]                 col;
    logic [nfs_pkg::DIST_W-1:0] dist_sq;
    logic                       found;
  } nearest_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic                       opcode_i    = 1'b0;
  logic [3:0]                 row_i       = '0;
  logic [3:0]                 column_i    = '0;
  logic signed [15:0]         reading_0_i = '0;
  logic signed [15:0]         reading_1_i = '0;
  logic signed [15:0]         reading_2_i = '0;
  logic signed [15:0]         reading_3_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [3:0]                 best_row_o;
  logic [3:0]                 best_col_o;
  logic [33:0]                best_dist_sq_o;
  logic                       found_o;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [nfs_pkg::APB_AW-1:0] paddr       = '0;
  logic [nfs_pkg::APB_DW-1:0] pwdata      = '0;
  logic [nfs_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  fp_word_t                  word_q[$];        // words waiting to be offered
  nearest_t                  nearest_q[$];     // predicted results, oldest first
  logic [3:0][15:0]          recent_prints[$]; // fingerprints lately written
  logic [3:0][15:0]          cal_grid [GRID_ROWS*GRID_COLS];  // shadow of the store
  logic [nfs_pkg::CFG_W-1:0] rows_cfg;
  logic [nfs_pkg::CFG_W-1:0] cols_cfg;
  fp_word_t                  next_word;
  logic                      word_taken = 1'b0;  // word on the bus accepted at last edge
  idle_mode_e                idle_mode  = IDLE_RX_HEAVY;
  int                        hold_req    = 0;    // back-pressure stretches asked for
  int                        hold_served = 0;
  int                        hold_left   = 0;
  int                        err_cnt     = 0;
  longint                    cycle_cnt   = 0;

  nearest_fingerprint_search_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .reading_0_i    (reading_0_i),
    .reading_1_i    (reading_1_i),
    .reading_2_i    (reading_2_i),
    .reading_3_i    (reading_3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_row_o     (best_row_o),
    .best_col_o     (best_col_o),
    .best_dist_sq_o (best_dist_sq_o),
    .found_o        (found_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor: row-major scan of the cells in use, strict less-than so the
  // first of equal distances wins. Register values above the grid saturate.
  // --------------------------------------------------------------------------
  function automatic nearest_t search_nearest(input logic [3:0][15:0] meas);
    nearest_t best;
    longint   best_d;
    longint   sum;
    longint   diff;
    int       nr;
    int       nc;
    best   = '0;
    best_d = 0;
    nr = int'(rows_cfg);
    nc = int'(cols_cfg);
    if (nr > GRID_ROWS) nr = GRID_ROWS;
    if (nc > GRID_COLS) nc = GRID_COLS;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        sum = 0;
        for (int s = 0; s < SENSOR_CNT; s++) begin
          diff = longint'($signed(meas[s])) - longint'($signed(cal_grid[r*GRID_COLS+c][s]));
          sum += diff * diff;
        end
        if (!best.found || sum < best_d) begin
          best.found = 1'b1;
          best_d     = sum;
          best.row   = 4'(r);
          best.col   = 4'(c);
        end
      end
    end
    best.dist_sq = best_d[nfs_pkg::DIST_W-1:0];
    return best;
  endfunction

  // Word just accepted: update the shadow grid or queue a prediction.
  // Row and column are 4 bits against a 16 by 16 grid, so no write falls
  // outside it.
  task automatic apply_word();
    logic [3:0][15:0] meas;
    meas = {reading_3_i, reading_2_i, reading_1_i, reading_0_i};
    if (opcode_i == nfs_pkg::OP_WRITE) begin
      cal_grid[int'(row_i)*GRID_COLS + int'(column_i)] = meas;
    end else begin
      nearest_q.push_back(search_nearest(meas));
    end
  endtask

  task automatic check_result();
    nearest_t want;
    if (nearest_q.size() == 0) begin
      $error("unexpected result: row %0d col %0d dist %0d found %0d",
             best_row_o, best_col_o, best_dist_sq_o, found_o);
      err_cnt++;
    end else begin
      want = nearest_q.pop_front();
      if (best_row_o !== want.row) begin
        $error("best_row: expected %0d, actual %0d", want.row, best_row_o);
        err_cnt++;
      end
      if (best_col_o !== want.col) begin
        $error("best_col: expected %0d, actual %0d", want.col, best_col_o);
        err_cnt++;
      end
      if (best_dist_sq_o !== want.dist_sq) begin
        $error("best_dist_sq: expected %0d, actual %0d", want.dist_sq, best_dist_sq_o);
        err_cnt++;
      end
      if (found_o !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found_o);
        err_cnt++;
      end
    end
  endtask

  function automatic int idle_pct(input bit is_sender);
    case (idle_mode)
      IDLE_RX_HEAVY: return is_sender ? 23 : 45;
      IDLE_TX_HEAVY: return is_sender ? 45 : 23;
      default:       return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Rising edge: sample both handshakes, run the cycle limit
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      word_taken <= rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && in_valid_i && !in_stall_o) apply_word();
      if (rst_ni && out_valid_o && !out_stall_i) check_result();
    end
  end

  // Driver: a new word only once the current one is taken, so a stalled
  // word holds still; valid never looks at stall
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (word_q.size() != 0 && $urandom_range(99, 0) >= idle_pct(1'b1)) begin
        next_word    = word_q.pop_front();
        in_valid_i  <= 1'b1;
        opcode_i    <= next_word.op;
        row_i       <= next_word.row;
        column_i    <= next_word.col;
        reading_0_i <= next_word.rd[0];
        reading_1_i <= next_word.rd[1];
        reading_2_i <= next_word.rd[2];
        reading_3_i <= next_word.rd[3];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < idle_pct(1'b0));
    end
  end

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access until pready
  // --------------------------------------------------------------------------
  task automatic apb_write(input nfs_pkg::reg_idx_e idx,
                           input logic [nfs_pkg::CFG_W-1:0] val);
    logic [nfs_pkg::APB_DW-1:0] junk;
    junk = nfs_pkg::APB_DW'($urandom);  // bits above the register should be dropped
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[nfs_pkg::APB_DW-1:nfs_pkg::CFG_W], val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == nfs_pkg::REG_ROWS) rows_cfg = val;
    else cols_cfg = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_readback(input nfs_pkg::reg_idx_e idx);
    logic [nfs_pkg::APB_DW-1:0] want;
    want = nfs_pkg::APB_DW'((idx == nfs_pkg::REG_ROWS) ? rows_cfg : cols_cfg);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("%s readback: expected %0d, actual %0d", idx.name(), want, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid(input logic [nfs_pkg::CFG_W-1:0] nrows,
                          input logic [nfs_pkg::CFG_W-1:0] ncols);
    apb_write(nfs_pkg::REG_ROWS, nrows);
    apb_write(nfs_pkg::REG_COLS, ncols);
    apb_readback(nfs_pkg::REG_ROWS);
    apb_readback(nfs_pkg::REG_COLS);
  endtask

  // Block is idle once every word is taken and every result is in
  task automatic wait_idle(input int settle);
    while (word_q.size() != 0 || in_valid_i || nearest_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic push_word(input nfs_pkg::opcode_e op, input logic [3:0] row,
                           input logic [3:0] col, input logic [3:0][15:0] rd);
    fp_word_t w;
    w.op  = op;
    w.row = row;
    w.col = col;
    w.rd  = rd;
    word_q.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Random words. Mostly writes inside the area in use, then queries, some
  // near what was written, so minima move about; duplicates make ties.
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_reading();
    case ($urandom_range(19, 0))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fp_word_t random_word(input int nr, input int nc);
    fp_word_t         w;
    int               kind;
    logic [3:0][15:0] base;
    w.op  = nfs_pkg::OP_WRITE;
    w.row = 4'($urandom);
    w.col = 4'($urandom);
    for (int s = 0; s < SENSOR_CNT; s++) w.rd[s] = pick_reading();
    kind = int'($urandom_range(99, 0));
    if (kind < 45) begin
      // write into the scanned area, a copy of a recent print now and then
      if (nr > 0 && nc > 0) begin
        w.row = 4'($urandom_range(nr - 1, 0));
        w.col = 4'($urandom_range(nc - 1, 0));
      end
      if (kind >= 35 && recent_prints.size() != 0)
        w.rd = recent_prints[$urandom_range(recent_prints.size() - 1, 0)];
    end else if (kind < 55) begin
      // write anywhere, in or out of the area in use
    end else if (kind < 75) begin
      w.op = nfs_pkg::OP_QUERY;
      if (recent_prints.size() != 0) begin
        base = recent_prints[$urandom_range(recent_prints.size() - 1, 0)];
        if ($urandom_range(2, 0) == 0) begin
          w.rd = base;  // exact hit
        end else begin
          for (int s = 0; s < SENSOR_CNT; s++)
            w.rd[s] = base[s] + 16'(int'($urandom_range(64, 0)) - 32);
        end
      end
    end else begin
      w.op = nfs_pkg::OP_QUERY;
    end
    if (w.op == nfs_pkg::OP_WRITE) begin
      recent_prints.push_back(w.rd);
      if (recent_prints.size() > 16) void'(recent_prints.pop_front());
    end
    return w;
  endfunction

  task automatic run_phase(input logic [nfs_pkg::CFG_W-1:0] nrows,
                           input logic [nfs_pkg::CFG_W-1:0] ncols,
                           input int count, input idle_mode_e mode, input bit squeeze);
    int nr;
    int nc;
    set_grid(nrows, ncols);
    idle_mode = mode;
    nr = (int'(nrows) > GRID_ROWS) ? GRID_ROWS : int'(nrows);
    nc = (int'(ncols) > GRID_COLS) ? GRID_COLS : int'(ncols);
    if (squeeze) hold_req++;
    repeat (count) word_q.push_back(random_word(nr, nc));
    wait_idle(SETTLE_CYCLES);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < GRID_ROWS * GRID_COLS; i++) cal_grid[i] = '0;
    rows_cfg = nfs_pkg::ROWS_RST;
    cols_cfg = nfs_pkg::COLS_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset grid size. The store reads zero after the clearing
    // pass, so every cell ties and the first one must win.
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h0000}});
    push_word(nfs_pkg::OP_QUERY, 4'hf, 4'hf, {4{16'h8000}});
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h7fff}});
    push_word(nfs_pkg::OP_WRITE, 4'hf, 4'hf, {4{16'h7fff}});
    push_word(nfs_pkg::OP_WRITE, 4'd0, 4'd0, {4{16'h8000}});
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h7fff}});    // last cell, exact
    push_word(nfs_pkg::OP_QUERY, 4'hf, 4'hf, {4{16'h8000}});    // first cell, exact
    push_word(nfs_pkg::OP_WRITE, 4'd7, 4'd9, {16'hedcc, 16'h1234, 16'hff00, 16'h0100});
    push_word(nfs_pkg::OP_WRITE, 4'd9, 4'd7, {16'hedcc, 16'h1234, 16'hff00, 16'h0100});
    // tie between the two copies
    push_word(nfs_pkg::OP_QUERY, 4'd3, 4'd3, {16'hedcc, 16'h1234, 16'hff00, 16'h0100});
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {16'hedcd, 16'h1235, 16'hff01, 16'h0101});
    push_word(nfs_pkg::OP_WRITE, 4'd5, 4'ha, {16'hffff, 16'h0001, 16'h8000, 16'h7fff});
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {16'hfffe, 16'h0000, 16'h8001, 16'h7ffe});
    wait_idle(SETTLE_CYCLES);

    // one cell holding the most negative print: largest distance there is
    set_grid(5'd1, 5'd1);
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h7fff}});
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h8000}});
    wait_idle(SETTLE_CYCLES);

    // empty grid either way: found low, all else zero
    set_grid(5'd0, 5'd16);
    push_word(nfs_pkg::OP_QUERY, 4'd2, 4'd3, {4{16'h1234}});
    wait_idle(SETTLE_CYCLES);
    set_grid(5'd16, 5'd0);
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h8000}});
    wait_idle(SETTLE_CYCLES);

    // counts above the grid saturate
    set_grid(5'd31, 5'd31);
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h7fff}});
    wait_idle(SETTLE_CYCLES);
    set_grid(5'd17, 5'd1);
    push_word(nfs_pkg::OP_QUERY, 4'd0, 4'd0, {4{16'h7fff}});
    wait_idle(SETTLE_CYCLES);

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    // Most words use small grids; full-size scans are slow.
    run_phase(5'd16, 5'd16, 120, IDLE_RX_HEAVY, 1'b0);
    run_phase(5'd3,  5'd5,  300, IDLE_RX_HEAVY, 1'b0);
    run_phase(5'd0,  5'd7,   50, IDLE_RX_HEAVY, 1'b0);
    run_phase(5'd1,  5'd1,  180, IDLE_RX_HEAVY, 1'b0);
    run_phase(5'd31, 5'd31, 100, IDLE_TX_HEAVY, 1'b0);
    run_phase(5'd2,  5'd16, 250, IDLE_TX_HEAVY, 1'b0);
    run_phase(5'd9,  5'd0,   50, IDLE_TX_HEAVY, 1'b0);
    run_phase(5'd16, 5'd1,  230, IDLE_NONE,     1'b0);
    run_phase(5'd20, 5'd4,  200, IDLE_NONE,     1'b0);
    // sender keeps offering while the receiver holds off: output register
    // fills, the next query waits and the input stalls
    run_phase(5'd5,  5'd3,  260, IDLE_NONE,     1'b1);

    wait_idle(DRAIN_CYCLES);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/nfs_pkg.sv
rtl/nfs_ram.sv
rtl/nfs_lane.sv
rtl/nfs_merge.sv
rtl/nearest_fingerprint_search_top.sv
rtl/nfs_checker.sv
verif/testbench.sv
